@@ sv/rcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_pkg
// Types, widths and protocol constants for the RTCP compound scanner.
// ----------------------------------------------------------------------------
package rcs_pkg;

  // sizing
  localparam int PACKET_BYTES = 2048;
  localparam int SLOTS        = 4;
  localparam int REG_SLOTS    = 4;
  localparam int SLOT_LIM     = (SLOTS < REG_SLOTS) ? SLOTS : REG_SLOTS;
  localparam int POS_W        = $clog2(PACKET_BYTES + 1);
  // a subpacket start can lie up to 4 * 65536 bytes past the packet window
  localparam int START_W      = $clog2(PACKET_BYTES + 4 * 65536 + 8);
  localparam int ITEM_W       = $clog2(PACKET_BYTES + 264);
  localparam int OFF_W        = 11;
  localparam int CNT_W        = 3;
  localparam int TYPE_W       = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_TYPE0 = 3'd1;

  // protocol constants
  localparam logic [1:0] VERSION_2 = 2'd2;
  localparam logic [1:0] VERSION_1 = 2'd1;
  localparam logic [7:0] PT_SR     = 8'd200;
  localparam logic [7:0] PT_RR     = 8'd201;
  localparam logic [7:0] PT_SDES   = 8'd202;
  localparam logic [7:0] PT_BYE    = 8'd203;
  localparam logic [7:0] ITEM_END  = 8'd0;

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [START_W-1:0] start_t;
  typedef logic [ITEM_W-1:0]  item_t;
  typedef logic [OFF_W-1:0]   off_t;

  typedef enum logic [1:0] {
    CM_FIRST,
    CM_WALK,
    CM_STOP,
    CM_BAD
  } cls_mode_t;

  typedef enum logic [1:0] {
    SM_SEARCH,
    SM_TYPE,
    SM_LEN,
    SM_DONE
  } sd_mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } rcs_in_t;

  typedef struct packed {
    logic        saw_bye;
    logic        saw_sdes;
    logic        sdes_success;
    logic [31:0] sdes_ssrc;
    logic [3:0]  found_mask;
    off_t        item_offset_0;
    off_t        item_offset_1;
    off_t        item_offset_2;
    off_t        item_offset_3;
  } rcs_out_t;

endpackage

@@ sv/rcs_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_in_if / rcs_out_if
// Valid/ready channels carrying packet bytes in and scan results out.
// ----------------------------------------------------------------------------
interface rcs_in_if;
  logic             valid;
  logic             ready;
  rcs_pkg::rcs_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rcs_out_if;
  logic              valid;
  logic              ready;
  rcs_pkg::rcs_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/rtcp_compound_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcp_compound_scanner
// Streams an RTCP compound packet, classifies it and locates SDES items.
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle on in_ch; the byte flagged last_byte ends
// the packet, and its result word shows on out_ch in the next cycle. Every
// byte goes through a single stage of compares and length adds that update
// the classifier and SDES walk state, so the sustained rate is one byte per
// clock. The result sits in a one-word output register: input is stalled
// only while that word is held and out_ch.ready is low. Bytes beyond
// PACKET_BYTES are ignored by both walks, though last_byte still ends the
// packet. The slot registers are written through cfg_we/cfg_index/cfg_wdata
// only while no packet is in flight; the user must ensure this (unchecked).
module rtcp_compound_scanner (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  rcs_in_if.sink                          in_ch,
  rcs_out_if.source                       out_ch
);

  // configuration
  logic [rcs_pkg::CNT_W-1:0]  slot_cnt_r;
  logic [rcs_pkg::TYPE_W-1:0] slot_type_r [rcs_pkg::REG_SLOTS];

  // walk state
  rcs_pkg::pos_t      pos_r;
  rcs_pkg::cls_mode_t cls_mode_r, cls_mode_nxt;
  rcs_pkg::start_t    cls_start_r, cls_start_nxt;
  logic [1:0]         cls_flags_r, cls_flags_nxt;
  logic [7:0]         cls_len_r, cls_len_nxt;
  rcs_pkg::sd_mode_t  sd_mode_r, sd_mode_nxt;
  rcs_pkg::start_t    sd_start_r, sd_start_nxt;
  logic               sd_sel_r, sd_sel_nxt;
  logic [7:0]         sd_len_r, sd_len_nxt;
  rcs_pkg::start_t    chunk_end_r, chunk_end_nxt;
  rcs_pkg::item_t     item_next_r, item_next_nxt;
  logic [31:0]        ssrc_r, ssrc_nxt;
  logic [rcs_pkg::REG_SLOTS-1:0] found_r, found_nxt;
  rcs_pkg::off_t      offset_r   [rcs_pkg::REG_SLOTS];
  rcs_pkg::off_t      offset_nxt [rcs_pkg::REG_SLOTS];

  // output register
  logic               out_valid_r;
  rcs_pkg::rcs_out_t  out_data_r, result;

  logic            in_acc;
  logic            active;
  logic [7:0]      b;
  logic [1:0]      ver;
  rcs_pkg::start_t pos_s;
  rcs_pkg::start_t cls_off, sd_off;
  logic            cls_in, sd_in;
  logic            res_valid;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign active       = (int'(pos_r) < rcs_pkg::PACKET_BYTES);
  assign b            = in_ch.data.data_byte;
  assign ver          = b[7:6];
  assign pos_s        = rcs_pkg::start_t'(pos_r);
  assign cls_in       = pos_s >= cls_start_r;
  assign cls_off      = pos_s - cls_start_r;
  assign sd_in        = pos_s >= sd_start_r;
  assign sd_off       = pos_s - sd_start_r;

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // classifier walk
  always_comb begin
    cls_mode_nxt  = cls_mode_r;
    cls_start_nxt = cls_start_r;
    cls_flags_nxt = cls_flags_r;
    cls_len_nxt   = cls_len_r;
    if (active) begin
      unique case (cls_mode_r)
        rcs_pkg::CM_FIRST: begin
          if (pos_r == '0) begin
            if ((ver != rcs_pkg::VERSION_2 && ver != rcs_pkg::VERSION_1) || b[5]) begin
              cls_mode_nxt = rcs_pkg::CM_BAD;
            end
          end else begin
            cls_mode_nxt = (b == rcs_pkg::PT_SR || b == rcs_pkg::PT_RR) ?
                           rcs_pkg::CM_WALK : rcs_pkg::CM_BAD;
          end
        end
        rcs_pkg::CM_WALK: begin
          if (cls_in) begin
            if (cls_off == rcs_pkg::start_t'(0)) begin
              if (ver != rcs_pkg::VERSION_2) cls_mode_nxt = rcs_pkg::CM_STOP;
            end else if (cls_off == rcs_pkg::start_t'(1)) begin
              if (b == rcs_pkg::PT_BYE)  cls_flags_nxt[0] = 1'b1;
              if (b == rcs_pkg::PT_SDES) cls_flags_nxt[1] = 1'b1;
            end else if (cls_off == rcs_pkg::start_t'(2)) begin
              cls_len_nxt = b;
            end else if (cls_off == rcs_pkg::start_t'(3)) begin
              // next header at start + (length + 1) * 4
              cls_start_nxt = cls_start_r + rcs_pkg::start_t'({cls_len_r, b, 2'b00})
                              + rcs_pkg::start_t'(4);
            end
          end
        end
        rcs_pkg::CM_STOP, rcs_pkg::CM_BAD: begin
        end
        default: begin
        end
      endcase
    end
  end

  // sdes walk
  always_comb begin
    logic hit;
    sd_mode_nxt   = sd_mode_r;
    sd_start_nxt  = sd_start_r;
    sd_sel_nxt    = sd_sel_r;
    sd_len_nxt    = sd_len_r;
    chunk_end_nxt = chunk_end_r;
    item_next_nxt = item_next_r;
    ssrc_nxt      = ssrc_r;
    found_nxt     = found_r;
    offset_nxt    = offset_r;
    hit           = 1'b0;
    if (active && sd_mode_r != rcs_pkg::SM_DONE && sd_in) begin
      if (sd_mode_r == rcs_pkg::SM_SEARCH) begin
        if (sd_off == rcs_pkg::start_t'(0)) begin
          if (ver != rcs_pkg::VERSION_2 && ver != rcs_pkg::VERSION_1) begin
            sd_mode_nxt = rcs_pkg::SM_DONE;
          end else begin
            sd_sel_nxt = (b[4:0] != 5'd0);
          end
        end else if (sd_off == rcs_pkg::start_t'(1)) begin
          if (b != rcs_pkg::PT_SDES) sd_sel_nxt = 1'b0;
        end else if (sd_off == rcs_pkg::start_t'(2)) begin
          sd_len_nxt = b;
        end else if (sd_off == rcs_pkg::start_t'(3)) begin
          if (sd_sel_r) begin
            chunk_end_nxt = sd_start_r + rcs_pkg::start_t'({sd_len_r, b, 2'b00})
                            + rcs_pkg::start_t'(4);
            item_next_nxt = rcs_pkg::item_t'(sd_start_r + rcs_pkg::start_t'(8));
            sd_mode_nxt   = rcs_pkg::SM_TYPE;
          end else begin
            sd_start_nxt = sd_start_r + rcs_pkg::start_t'({sd_len_r, b, 2'b00})
                           + rcs_pkg::start_t'(4);
          end
        end
      end else if (sd_off >= rcs_pkg::start_t'(4) && sd_off <= rcs_pkg::start_t'(7)) begin
        ssrc_nxt = {ssrc_r[23:0], b};
      end else if (sd_mode_r == rcs_pkg::SM_TYPE &&
                   pos_s == rcs_pkg::start_t'(item_next_r)) begin
        if (pos_s >= chunk_end_r || b == rcs_pkg::ITEM_END) begin
          sd_mode_nxt = rcs_pkg::SM_DONE;
        end else begin
          // first unused slot with a matching type takes the item
          for (int i = 0; i < rcs_pkg::REG_SLOTS; i++) begin
            if (!hit && i < rcs_pkg::SLOT_LIM && i < int'(slot_cnt_r) &&
                slot_type_r[i] == b && !found_r[i]) begin
              hit           = 1'b1;
              found_nxt[i]  = 1'b1;
              offset_nxt[i] = pos_r[rcs_pkg::OFF_W-1:0];
            end
          end
          sd_mode_nxt = rcs_pkg::SM_LEN;
        end
      end else if (sd_mode_r == rcs_pkg::SM_LEN &&
                   pos_s == rcs_pkg::start_t'(item_next_r) + rcs_pkg::start_t'(1)) begin
        item_next_nxt = item_next_r + rcs_pkg::item_t'(b) + rcs_pkg::item_t'(2);
        sd_mode_nxt   = rcs_pkg::SM_TYPE;
      end
    end
  end

  // result word from the state after this byte
  always_comb begin
    res_valid            = (cls_mode_nxt == rcs_pkg::CM_WALK ||
                            cls_mode_nxt == rcs_pkg::CM_STOP);
    result.saw_bye       = res_valid && cls_flags_nxt[0];
    result.saw_sdes      = res_valid && cls_flags_nxt[1];
    result.sdes_success  = (found_nxt != '0);
    result.sdes_ssrc     = ssrc_nxt;
    result.found_mask    = found_nxt;
    result.item_offset_0 = found_nxt[0] ? offset_nxt[0] : '0;
    result.item_offset_1 = found_nxt[1] ? offset_nxt[1] : '0;
    result.item_offset_2 = found_nxt[2] ? offset_nxt[2] : '0;
    result.item_offset_3 = found_nxt[3] ? offset_nxt[3] : '0;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_cnt_r <= '0;
      for (int i = 0; i < rcs_pkg::REG_SLOTS; i++) slot_type_r[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == rcs_pkg::REG_SLOT_COUNT) begin
        slot_cnt_r <= cfg_wdata[rcs_pkg::CNT_W-1:0];
      end
      for (int i = 0; i < rcs_pkg::REG_SLOTS; i++) begin
        if (cfg_index == rcs_pkg::REG_SLOT_TYPE0 + rcs_pkg::CFG_IDX_W'(i)) begin
          slot_type_r[i] <= cfg_wdata[rcs_pkg::TYPE_W-1:0];
        end
      end
    end
  end

  // walk state: cleared at reset and after each packet
  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && in_ch.data.last_byte)) begin
      pos_r       <= '0;
      cls_mode_r  <= rcs_pkg::CM_FIRST;
      cls_start_r <= '0;
      cls_flags_r <= '0;
      cls_len_r   <= '0;
      sd_mode_r   <= rcs_pkg::SM_SEARCH;
      sd_start_r  <= '0;
      sd_sel_r    <= 1'b0;
      sd_len_r    <= '0;
      chunk_end_r <= '0;
      item_next_r <= '0;
      ssrc_r      <= '0;
      found_r     <= '0;
      for (int i = 0; i < rcs_pkg::REG_SLOTS; i++) offset_r[i] <= '0;
    end else if (in_acc) begin
      if (active) pos_r <= pos_r + rcs_pkg::pos_t'(1);
      cls_mode_r  <= cls_mode_nxt;
      cls_start_r <= cls_start_nxt;
      cls_flags_r <= cls_flags_nxt;
      cls_len_r   <= cls_len_nxt;
      sd_mode_r   <= sd_mode_nxt;
      sd_start_r  <= sd_start_nxt;
      sd_sel_r    <= sd_sel_nxt;
      sd_len_r    <= sd_len_nxt;
      chunk_end_r <= chunk_end_nxt;
      item_next_r <= item_next_nxt;
      ssrc_r      <= ssrc_nxt;
      found_r     <= found_nxt;
      offset_r    <= offset_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && in_ch.data.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.data.last_byte) begin
      out_data_r <= result;
    end
  end

endmodule

@@ sv/rcs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_checker
// Port-level checks for the RTCP compound scanner, bound to the top level.
// ----------------------------------------------------------------------------
module rcs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_last,
  input logic              out_valid,
  input logic              out_ready,
  input rcs_pkg::rcs_out_t out_data
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a held result word does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped or changed while stalled");

  // the last byte of a packet yields a result word next cycle
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last |=> out_valid)
    else $error("no result after last byte");

  // no word appears without a last byte
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && in_last) && !(out_valid && !out_ready) |=> !out_valid)
    else $error("result word without a last byte");

  // success flag and offsets agree with the found mask
  a_mask_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.sdes_success == (out_data.found_mask != 4'd0)) &&
                  (out_data.found_mask[0] || out_data.item_offset_0 == '0) &&
                  (out_data.found_mask[1] || out_data.item_offset_1 == '0) &&
                  (out_data.found_mask[2] || out_data.item_offset_2 == '0) &&
                  (out_data.found_mask[3] || out_data.item_offset_3 == '0))
    else $error("found mask inconsistent with success or offsets");

endmodule

bind rtcp_compound_scanner rcs_checker u_rcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.data.last_byte),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

@@ tb/rcs_scan_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcs_scan_checker
// Watches the byte and result channels of the RTCP compound scanner. It keeps
// its own model of the classifier and SDES walks and its own copy of the slot
// registers. It checks every result word, field by field, against the oldest
// prediction.
// ----------------------------------------------------------------------------
module rcs_scan_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  rcs_pkg::rcs_in_t               in_word,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  rcs_pkg::rcs_out_t              out_word,
  output int                             fail_cnt,
  output int                             pend_cnt,
  output int                             n_bytes,
  output int                             n_results,
  output int                             n_valid,
  output int                             n_located
);

  // register copy
  logic [rcs_pkg::CNT_W-1:0]  slot_cnt;
  logic [rcs_pkg::TYPE_W-1:0] slot_type [rcs_pkg::REG_SLOTS];

  // walk state
  rcs_pkg::pos_t      at_pos;
  rcs_pkg::start_t    cls_start;
  rcs_pkg::cls_mode_t cls_mode;
  logic [1:0]         cls_seen;      // bit 0 bye, bit 1 sdes
  logic [7:0]         cls_len_hi;
  rcs_pkg::start_t    sd_start;
  rcs_pkg::sd_mode_t  sd_mode;
  logic               sd_has_items;
  logic [7:0]         sd_len_hi;
  rcs_pkg::start_t    chunk_lim;
  rcs_pkg::item_t     item_at;
  logic [31:0]        ssrc_acc;
  logic [3:0]         hit_mask;
  rcs_pkg::off_t      hit_off [rcs_pkg::REG_SLOTS];

  rcs_pkg::rcs_out_t scan_q [$];
  int                errors;
  int                bytes_seen;
  int                results_seen;
  int                valid_seen;
  int                located_seen;

  function automatic void clear_walk();
    at_pos       = '0;
    cls_start    = '0;
    cls_mode     = rcs_pkg::CM_FIRST;
    cls_seen     = '0;
    cls_len_hi   = '0;
    sd_start     = '0;
    sd_mode      = rcs_pkg::SM_SEARCH;
    sd_has_items = 1'b0;
    sd_len_hi    = '0;
    chunk_lim    = '0;
    item_at      = '0;
    ssrc_acc     = '0;
    hit_mask     = '0;
    foreach (hit_off[i]) hit_off[i] = '0;
  endfunction

  task automatic report_fail(input string msg);
    $display("%0t  scan mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_fail($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic lst);
    rcs_pkg::rcs_out_t res;
    int                p;
    int                o;
    int                nxt;
    int                n;
    int                hit;
    logic [1:0]        ver;
    p   = int'(at_pos);
    ver = b[7:6];
    if (p < rcs_pkg::PACKET_BYTES) begin
      // classifier
      if (cls_mode == rcs_pkg::CM_FIRST) begin
        if (p == 0) begin
          if ((ver != rcs_pkg::VERSION_2 && ver != rcs_pkg::VERSION_1) || b[5])
            cls_mode = rcs_pkg::CM_BAD;
        end else if (p == 1) begin
          cls_mode = (b == rcs_pkg::PT_SR || b == rcs_pkg::PT_RR) ?
                     rcs_pkg::CM_WALK : rcs_pkg::CM_BAD;
        end
      end else if (cls_mode == rcs_pkg::CM_WALK && p >= int'(cls_start)) begin
        o = p - int'(cls_start);
        case (o)
          0: if (ver != rcs_pkg::VERSION_2) cls_mode = rcs_pkg::CM_STOP;
          1: begin
            if (b == rcs_pkg::PT_BYE) cls_seen[0] = 1'b1;
            if (b == rcs_pkg::PT_SDES) cls_seen[1] = 1'b1;
          end
          2: cls_len_hi = b;
          3: cls_start = rcs_pkg::start_t'(int'(cls_start) + (int'({cls_len_hi, b}) + 1) * 4);
          default: ;
        endcase
      end
      // sdes walk
      if (sd_mode != rcs_pkg::SM_DONE && p >= int'(sd_start)) begin
        o = p - int'(sd_start);
        if (sd_mode == rcs_pkg::SM_SEARCH) begin
          case (o)
            0: begin
              if (ver != rcs_pkg::VERSION_2 && ver != rcs_pkg::VERSION_1) begin
                sd_mode = rcs_pkg::SM_DONE;
              end else begin
                sd_has_items = (b[4:0] != 5'd0);
                sd_len_hi    = '0;
              end
            end
            1: if (b != rcs_pkg::PT_SDES) sd_has_items = 1'b0;
            2: sd_len_hi = b;
            3: begin
              nxt = int'(sd_start) + (int'({sd_len_hi, b}) + 1) * 4;
              if (sd_has_items) begin
                chunk_lim = rcs_pkg::start_t'(nxt);
                item_at   = rcs_pkg::item_t'(int'(sd_start) + 8);
                sd_mode   = rcs_pkg::SM_TYPE;
              end else begin
                sd_start = rcs_pkg::start_t'(nxt);
              end
            end
            default: ;
          endcase
        end else if (o >= 4 && o <= 7) begin
          ssrc_acc = {ssrc_acc[23:0], b};
        end else if (sd_mode == rcs_pkg::SM_TYPE && p == int'(item_at)) begin
          if (p >= int'(chunk_lim) || b == rcs_pkg::ITEM_END) begin
            sd_mode = rcs_pkg::SM_DONE;
          end else begin
            n   = (int'(slot_cnt) < rcs_pkg::SLOT_LIM) ? int'(slot_cnt) : rcs_pkg::SLOT_LIM;
            hit = -1;
            for (int i = 0; i < n; i++)
              if (hit < 0 && slot_type[i] == b && !hit_mask[i]) hit = i;
            if (hit >= 0) begin
              hit_mask[hit] = 1'b1;
              hit_off[hit]  = rcs_pkg::off_t'(p);
            end
            sd_mode = rcs_pkg::SM_LEN;
          end
        end else if (sd_mode == rcs_pkg::SM_LEN && p == int'(item_at) + 1) begin
          item_at = rcs_pkg::item_t'(int'(item_at) + 2 + int'(b));
          sd_mode = rcs_pkg::SM_TYPE;
        end
      end
      at_pos = at_pos + 1'b1;
    end
    if (lst) begin
      res.saw_bye       = (cls_mode == rcs_pkg::CM_WALK || cls_mode == rcs_pkg::CM_STOP) &&
                          cls_seen[0];
      res.saw_sdes      = (cls_mode == rcs_pkg::CM_WALK || cls_mode == rcs_pkg::CM_STOP) &&
                          cls_seen[1];
      res.sdes_success  = |hit_mask;
      res.sdes_ssrc     = ssrc_acc;
      res.found_mask    = hit_mask;
      res.item_offset_0 = hit_off[0];
      res.item_offset_1 = hit_off[1];
      res.item_offset_2 = hit_off[2];
      res.item_offset_3 = hit_off[3];
      scan_q.push_back(res);
      if (cls_mode == rcs_pkg::CM_WALK || cls_mode == rcs_pkg::CM_STOP) valid_seen++;
      if (res.sdes_success) located_seen++;
      clear_walk();
    end
  endtask

  always @(posedge clk) begin : watch
    rcs_pkg::rcs_out_t want;
    if (!rst_n) begin
      clear_walk();
      slot_cnt = '0;
      foreach (slot_type[i]) slot_type[i] = '0;
      scan_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == rcs_pkg::REG_SLOT_COUNT)
          slot_cnt = cfg_wdata[rcs_pkg::CNT_W-1:0];
        else if (cfg_index >= rcs_pkg::REG_SLOT_TYPE0 &&
                 cfg_index < rcs_pkg::REG_SLOT_TYPE0 + rcs_pkg::REG_SLOTS)
          slot_type[cfg_index - rcs_pkg::REG_SLOT_TYPE0] = cfg_wdata;
      end
      // a result word always belongs to an earlier packet than a byte taken now
      if (out_valid && out_ready) begin
        results_seen++;
        if (scan_q.size() == 0) begin
          report_fail("result word with no packet outstanding");
        end else begin
          want = scan_q.pop_front();
          check_field("saw_bye", out_word.saw_bye, want.saw_bye);
          check_field("saw_sdes", out_word.saw_sdes, want.saw_sdes);
          check_field("sdes_success", out_word.sdes_success, want.sdes_success);
          check_field("sdes_ssrc", out_word.sdes_ssrc, want.sdes_ssrc);
          check_field("found_mask", out_word.found_mask, want.found_mask);
          check_field("item_offset_0", out_word.item_offset_0, want.item_offset_0);
          check_field("item_offset_1", out_word.item_offset_1, want.item_offset_1);
          check_field("item_offset_2", out_word.item_offset_2, want.item_offset_2);
          check_field("item_offset_3", out_word.item_offset_3, want.item_offset_3);
        end
      end
      if (in_valid && in_ready) begin
        bytes_seen++;
        scan_byte(in_word.data_byte, in_word.last_byte);
      end
    end
    fail_cnt  <= errors;
    pend_cnt  <= scan_q.size();
    n_bytes   <= bytes_seen;
    n_results <= results_seen;
    n_valid   <= valid_seen;
    n_located <= located_seen;
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the RTCP compound scanner. A short directed set
// of packets comes first. Then several slot settings follow, each with random
// compound packets: mostly well formed, some cut short, corrupted or pure
// noise. Both channels stall in random bursts, but for two of the phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int QUIET_LIMIT  = 1000;
  localparam int PHASES       = 8;
  localparam int PHASE_BYTES  = 210;
  localparam int PHASE_PKTS   = 6;
  localparam logic [7:0] PT_APP = 8'd204;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [rcs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rcs_pkg::CFG_DATA_W-1:0] cfg_wdata;

  rcs_in_if  in_ch ();
  rcs_out_if out_ch ();

  int fail_cnt;
  int pend_cnt;
  int n_bytes;
  int n_results;
  int n_valid;
  int n_located;

  bit          stall_en = 1'b1;
  logic [7:0]  pkt_q [$];
  logic [2:0]  want_cnt;
  logic [7:0]  want_type [rcs_pkg::REG_SLOTS];
  int          n_settings;
  int          phase_bytes;

  rtcp_compound_scanner u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  rcs_scan_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_word   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_ch.data),
    .fail_cnt  (fail_cnt),
    .pend_cnt  (pend_cnt),
    .n_bytes   (n_bytes),
    .n_results (n_results),
    .n_valid   (n_valid),
    .n_located (n_located)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side backpressure
  initial begin : ready_gen
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_en && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no traffic for %0d cycles", QUIET_LIMIT);
    $display("[rtcp_compound_scanner] ERROR");
    $finish;
  end

  // mostly small item types so that requested slots match often
  function automatic logic [7:0] pick_type();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return 8'($urandom_range(1, 6));
    if (r < 16) return 8'hFF;
    if (r < 17) return 8'h00;
    return 8'($urandom);
  endfunction

  function automatic logic [1:0] pick_ver();
    return ($urandom_range(0, 7) == 0) ? rcs_pkg::VERSION_1 : rcs_pkg::VERSION_2;
  endfunction

  function automatic void put_subpacket(input logic [1:0] ver, input logic [4:0] cnt,
                                        input logic [7:0] pt, input logic [15:0] words);
    pkt_q.push_back({ver, 1'b0, cnt});
    pkt_q.push_back(pt);
    pkt_q.push_back(words[15:8]);
    pkt_q.push_back(words[7:0]);
    repeat (4 * int'(words)) pkt_q.push_back(8'($urandom));
  endfunction

  function automatic void put_sdes();
    logic [7:0]  body [$];
    logic [15:0] words;
    logic [4:0]  cnt;
    int          len;
    int          r;
    repeat (4) body.push_back(8'($urandom));
    repeat ($urandom_range(0, 4)) begin
      len = $urandom_range(0, 5);
      body.push_back(pick_type());
      body.push_back(8'(len));
      repeat (len) body.push_back(8'($urandom));
    end
    if ($urandom_range(0, 4) != 0) body.push_back(rcs_pkg::ITEM_END);
    while (body.size() % 4 != 0) body.push_back(8'h00);
    words = 16'(body.size() / 4);
    r = $urandom_range(0, 19);
    if (r == 0) words = 16'hFFFF;
    else if (r < 3) words = 16'($urandom_range(0, 7));
    r = $urandom_range(0, 9);
    cnt = (r == 0) ? 5'd0 : (r == 1) ? 5'($urandom_range(2, 31)) : 5'd1;
    pkt_q.push_back({pick_ver(), 1'b0, cnt});
    pkt_q.push_back(rcs_pkg::PT_SDES);
    pkt_q.push_back(words[15:8]);
    pkt_q.push_back(words[7:0]);
    foreach (body[i]) pkt_q.push_back(body[i]);
  endfunction

  function automatic void put_compound();
    int r;
    put_subpacket(pick_ver(), 5'($urandom),
                  ($urandom_range(0, 1) == 0) ? rcs_pkg::PT_SR : rcs_pkg::PT_RR,
                  16'($urandom_range(0, 3)));
    repeat ($urandom_range(0, 4)) begin
      r = $urandom_range(0, 9);
      if (r < 4)
        put_sdes();
      else if (r < 6)
        put_subpacket(pick_ver(), 5'($urandom), rcs_pkg::PT_BYE, 16'($urandom_range(0, 2)));
      else if (r < 7)
        put_subpacket(pick_ver(), 5'($urandom), PT_APP, 16'($urandom_range(0, 2)));
      else
        put_subpacket(2'($urandom), 5'($urandom), 8'($urandom), 16'($urandom_range(0, 2)));
    end
  endfunction

  function automatic void build_random_packet();
    int k;
    k = $urandom_range(0, 99);
    pkt_q = {};
    if (k < 88) begin
      put_compound();
      if (k >= 55 && k < 70 && pkt_q.size() > 1)
        pkt_q = pkt_q[0:$urandom_range(1, pkt_q.size() - 1) - 1];
      else if (k >= 70 && k < 80)
        pkt_q[$urandom_range(0, pkt_q.size() - 1)] = 8'($urandom);
      else if (k >= 80)
        pkt_q[0] = 8'($urandom);
    end else begin
      // noise, sometimes behind a good first header
      if ($urandom_range(0, 1) == 0) pkt_q = {8'h80, rcs_pkg::PT_SR};
      repeat ($urandom_range(1, 24)) pkt_q.push_back(8'($urandom));
    end
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic lst);
    if (stall_en && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{data_byte: b, last_byte: lst};
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_q.size(); i++) push_byte(pkt_q[i], i == pkt_q.size() - 1);
    phase_bytes += (pkt_q.size() < rcs_pkg::PACKET_BYTES) ? pkt_q.size() :
                   rcs_pkg::PACKET_BYTES;
  endtask

  // drain: lower valid, then wait for the last result
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pend_cnt != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_slots();
    cfg_we    <= 1'b1;
    cfg_index <= rcs_pkg::REG_SLOT_COUNT;
    cfg_wdata <= rcs_pkg::CFG_DATA_W'(want_cnt);
    @(posedge clk);
    for (int i = 0; i < rcs_pkg::REG_SLOTS; i++) begin
      cfg_index <= rcs_pkg::REG_SLOT_TYPE0 + rcs_pkg::CFG_IDX_W'(i);
      cfg_wdata <= want_type[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin : stim
    int n_pkts;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_wdata   <= '0;
    rst_n       <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    want_cnt  = 3'd2;
    want_type = '{8'd1, 8'd2, 8'hFF, 8'h00};
    load_slots();

    // short packet, all ones
    pkt_q = {8'hFF};
    send_packet();
    // first header cut off right after its type byte
    pkt_q = {8'h80, rcs_pkg::PT_SR};
    send_packet();
    // padding bit set
    pkt_q = {8'hA0, rcs_pkg::PT_SR, 8'h00};
    send_packet();
    // version 1 receiver report, nothing after it
    pkt_q = {8'h40, rcs_pkg::PT_RR, 8'h00, 8'h00};
    send_packet();
    // report then an SDES with one wanted item and an end item
    pkt_q = {8'h80, rcs_pkg::PT_SR, 8'h00, 8'h00, 8'h81, rcs_pkg::PT_SDES, 8'h00, 8'h02,
             8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'h01, 8'h00, rcs_pkg::ITEM_END, 8'h00};
    send_packet();

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          want_cnt  = 3'd4;
          want_type = '{8'd1, 8'd2, 8'd3, 8'd4};
        end
        1: begin
          want_cnt  = 3'd7;
          want_type = '{8'hFF, 8'h00, 8'd1, 8'd1};
        end
        2: begin
          want_cnt = 3'd0;
          foreach (want_type[i]) want_type[i] = pick_type();
        end
        3: begin
          want_cnt  = 3'd1;
          want_type = '{8'd2, 8'hFF, 8'hFF, 8'hFF};
        end
        default: begin
          want_cnt = 3'($urandom_range(0, 7));
          foreach (want_type[i]) want_type[i] = pick_type();
        end
      endcase
      load_slots();
      stall_en    = (ph != 3 && ph != PHASES - 1);
      phase_bytes = 0;
      n_pkts      = 0;
      while (phase_bytes < PHASE_BYTES || n_pkts < PHASE_PKTS) begin
        build_random_packet();
        send_packet();
        n_pkts++;
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("scanned %0d bytes in %0d packets under %0d slot settings",
             n_bytes, n_results, n_settings);
    $display("%0d packets classified valid, %0d with requested SDES items located",
             n_valid, n_located);
    if (fail_cnt == 0 && pend_cnt == 0)
      $display("[rtcp_compound_scanner] OK");
    else
      $display("[rtcp_compound_scanner] ERROR");
    $finish;
  end

endmodule
